// File: hdl/lrev_pkg.sv
// ----------------------------------------------------------------------------
// lrev_pkg: shared types and constants for the lidar revolution assembler
// Holds the transfer structs, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lrev_pkg;

  // Default geometry of one revolution
  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned PACKETS_DEF  = 128;
  localparam int unsigned POINTS_DEF   = 2048;

  // Width of the frame epoch mark kept beside every stored point
  localparam int unsigned EPOCH_W = 8;

  // Range pattern returned for a point that was never received (+infinity)
  localparam logic [31:0] INF_BITS = 32'h7F80_0000;

  // Per-item status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_DUP   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Input item
  typedef struct packed {
    logic        cmd;
    logic [15:0] rotation_count;
    logic [15:0] rotation_hz;
    logic [31:0] stamp_seconds;
    logic [31:0] stamp_fraction;
    logic [15:0] first_point;
    logic [3:0]  channel;
    logic [31:0] range_bits;
    logic [31:0] intensity_bits;
    logic [10:0] read_index;
  } in_t;

  // Result item
  typedef struct packed {
    logic [1:0]  status;
    logic        frame_complete;
    logic [7:0]  packets_held;
    logic [31:0] discarded_total;
    logic [15:0] rotation_now;
    logic [15:0] rotation_hz_now;
    logic [31:0] stamp_seconds_now;
    logic [31:0] stamp_fraction_now;
    logic [31:0] range_out;
    logic [31:0] intensity_out;
  } out_t;

  // Controller states
  typedef enum logic [2:0] {
    S_INIT,   // sweep epoch marks after reset
    S_IDLE,   // wait for start
    S_EXEC,   // judge and store a point, or launch a read
    S_READ,   // finish a read from the stores
    S_WRAP    // sweep epoch marks before the epoch wraps
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;      // latch the input item
    logic exec;         // perform the item's work
    logic read_fin;     // form the read result from memory data
    logic sweep;        // write one epoch mark to zero
    logic epoch_clear;  // restart epoch numbering after a sweep
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_read;      // latched item is a read
    logic need_wrap;    // item restarts the frame with the epoch at its top
    logic sweep_last;   // sweep is at the last entry
  } dp_status_t;

endpackage

// File: hdl/lrev_ram.sv
// ----------------------------------------------------------------------------
// lrev_ram: generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lrev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lrev_ctrl.sv
// ----------------------------------------------------------------------------
// lrev_ctrl: sequencing controller
// Accepts one item at a time, steps it through execute and read phases and
// runs the epoch mark sweeps after reset and before an epoch wrap.
// ----------------------------------------------------------------------------
module lrev_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  lrev_pkg::dp_status_t   dp_stat,
  output lrev_pkg::ctrl_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);
  import lrev_pkg::*;

  state_t state;
  state_t state_next;
  logic   done_next;

  // State register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (dp_stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (dp_stat.is_read) begin
          state_next = S_READ;
        end else if (dp_stat.need_wrap) begin
          state_next = S_WRAP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      S_WRAP: begin
        if (dp_stat.sweep_last) state_next = S_EXEC;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    done_next = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
      end
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_EXEC: begin
        if (dp_stat.is_read || !dp_stat.need_wrap) begin
          cmd.exec = 1'b1;
        end
        done_next = !dp_stat.is_read && !dp_stat.need_wrap;
      end
      S_READ: begin
        cmd.read_fin = 1'b1;
        done_next    = 1'b1;
      end
      S_WRAP: begin
        cmd.sweep       = 1'b1;
        cmd.epoch_clear = dp_stat.sweep_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // A transfer in always makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result only follows a cycle of work
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // No execution and sweep at once
  a_exec_sweep: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && cmd.sweep))
    else $error("execute and sweep overlap");

endmodule

// File: hdl/lrev_datapath.sv
// ----------------------------------------------------------------------------
// lrev_datapath: frame state, packet judging and point stores
// Holds the current frame header, received-slot map, tallies and the point
// stores. Every stored point carries the epoch of the frame that wrote it.
// ----------------------------------------------------------------------------
module lrev_datapath #(
  parameter int unsigned CHANNELS = lrev_pkg::CHANNELS_DEF,
  parameter int unsigned PACKETS  = lrev_pkg::PACKETS_DEF,
  parameter int unsigned POINTS   = lrev_pkg::POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lrev_pkg::in_t        item,
  input  lrev_pkg::ctrl_cmd_t  cmd,
  output lrev_pkg::dp_status_t dp_stat,
  output lrev_pkg::out_t       result
);
  import lrev_pkg::*;

  localparam int unsigned AW        = $clog2(POINTS);
  localparam int unsigned SW        = (PACKETS > 1) ? $clog2(PACKETS) : 1;
  localparam int unsigned TW        = $clog2(PACKETS + 1);
  localparam int unsigned CH_LOG    = $clog2(CHANNELS);
  localparam int unsigned DIV_SHIFT = 16 + CH_LOG;
  localparam int unsigned DIV_MUL   = ((1 << DIV_SHIFT) + CHANNELS - 1) / CHANNELS;
  localparam int unsigned LAST_CH   = CHANNELS - 1;
  localparam logic [16:0] DIV_MUL_V = 17'(DIV_MUL);

  // Latched item and its packet slot
  in_t         cur;
  logic [15:0] slot_q;
  logic [15:0] div_src;
  logic [32:0] div_prod;
  logic [15:0] slot_calc;

  // Frame state
  logic               frame_open;
  logic               frame_done;
  logic [15:0]        frame_rotation;
  logic [15:0]        frame_hz;
  logic [31:0]        frame_seconds;
  logic [31:0]        frame_fraction;
  logic [TW-1:0]      packet_tally;
  logic [31:0]        discard_tally;
  logic [PACKETS-1:0] slot_received;
  status_t            packet_verdict;
  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      sweep_addr;
  logic               read_hit_pre;

  // Result registers
  status_t     res_status;
  logic [31:0] res_range;
  logic [31:0] res_inten;

  // Judging
  logic [15:0]        rot_diff;
  logic               rot_differs;
  logic               stale;
  logic               first_ch;
  logic               last_ch;
  logic               chan_bad;
  logic               restart;
  logic               slot_ok;
  logic [SW-1:0]      slot_idx;
  logic               slot_seen;
  logic               received_now;
  status_t            verdict_new;
  status_t            verdict_eff;
  logic               open_after;
  logic [16:0]        pt;
  logic               pt_ok;
  logic               accepted;
  logic               mark;
  logic               upd;
  logic               store_we;
  logic               latch_hdr;
  status_t            pt_status;
  logic [TW-1:0]      tally_next;
  logic [PACKETS-1:0] mark_vec;
  logic [EPOCH_W-1:0] epoch_after;
  logic               idx_ok;
  logic               read_hit;

  // Memories
  logic               tag_we;
  logic [AW-1:0]      tag_waddr;
  logic [EPOCH_W-1:0] tag_wdata;
  logic [EPOCH_W-1:0] tag_rdata;
  logic [63:0]        data_rdata;
  logic [AW-1:0]      read_addr;

  // Divide first point or read index by the channel count (reciprocal multiply)
  assign div_src   = item.cmd ? {5'b0, item.read_index} : item.first_point;
  assign div_prod  = 33'(div_src) * 33'(DIV_MUL_V);
  assign slot_calc = 16'(div_prod >> DIV_SHIFT);

  // Hold the item for its execution
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur    <= item;
      slot_q <= slot_calc;
    end
  end

  // Judge the packet header and the point
  always_comb begin
    rot_diff     = cur.rotation_count - frame_rotation;
    rot_differs  = cur.rotation_count != frame_rotation;
    stale        = frame_open && rot_differs && rot_diff[15];
    first_ch     = cur.channel == 4'd0;
    last_ch      = 32'(cur.channel) == LAST_CH;
    chan_bad     = 32'(cur.channel) > LAST_CH;
    restart      = first_ch && (!frame_open || (rot_differs && !rot_diff[15]));
    slot_ok      = 32'(slot_q) < PACKETS;
    slot_idx     = slot_q[SW-1:0];
    slot_seen    = slot_ok && slot_received[slot_idx];
    received_now = !restart && slot_seen;
    epoch_after  = restart ? epoch + EPOCH_W'(1) : epoch;

    priority if (stale) begin
      verdict_new = ST_STALE;
    end else if (!slot_ok) begin
      verdict_new = ST_RANGE;
    end else if (received_now) begin
      verdict_new = ST_DUP;
    end else begin
      verdict_new = ST_OK;
    end

    verdict_eff = first_ch ? verdict_new : packet_verdict;
    open_after  = frame_open || restart;
    pt          = 17'(cur.first_point) + 17'(cur.channel);
    pt_ok       = 32'(pt) < POINTS;
    accepted    = !chan_bad && open_after && (verdict_eff == ST_OK);
    mark        = accepted && last_ch && slot_ok && !received_now;
    latch_hdr   = first_ch && (verdict_new == ST_OK) && (cur.first_point == 16'd0);

    priority if (chan_bad) begin
      pt_status = ST_RANGE;
    end else if (!open_after) begin
      pt_status = ST_STALE;
    end else if (verdict_eff != ST_OK) begin
      pt_status = verdict_eff;
    end else if (!pt_ok) begin
      pt_status = ST_RANGE;
    end else begin
      pt_status = ST_OK;
    end

    upd        = cmd.exec && !cur.cmd;
    store_we   = upd && accepted && pt_ok;
    tally_next = (restart ? '0 : packet_tally) + TW'(mark);
    mark_vec   = mark ? (PACKETS'(1) << slot_idx) : '0;
  end

  // Read lookup
  assign idx_ok    = 32'(cur.read_index) < POINTS;
  assign read_addr = AW'(cur.read_index);
  assign read_hit  = read_hit_pre && (tag_rdata == epoch);

  // Update frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open     <= 1'b0;
      frame_done     <= 1'b0;
      frame_rotation <= '0;
      frame_hz       <= '0;
      frame_seconds  <= '0;
      frame_fraction <= '0;
      packet_tally   <= '0;
      discard_tally  <= '0;
      slot_received  <= '0;
      packet_verdict <= ST_OK;
      epoch          <= '0;
    end else begin
      if (cmd.epoch_clear) begin
        epoch <= '0;
      end
      if (upd && !chan_bad) begin
        if (restart) begin
          if (frame_open && !frame_done && (packet_tally != '0) && (discard_tally != '1)) begin
            discard_tally <= discard_tally + 32'd1;
          end
          frame_open     <= 1'b1;
          frame_rotation <= cur.rotation_count;
          epoch          <= epoch_after;
        end
        if (restart || latch_hdr) begin
          frame_hz       <= cur.rotation_hz;
          frame_seconds  <= cur.stamp_seconds;
          frame_fraction <= cur.stamp_fraction;
        end
        if (first_ch) begin
          packet_verdict <= verdict_new;
        end
        packet_tally  <= tally_next;
        slot_received <= (restart ? '0 : slot_received) | mark_vec;
        if (mark) begin
          frame_done <= 32'(tally_next) == PACKETS;
        end else if (restart) begin
          frame_done <= 1'b0;
        end
      end
    end
  end

  // Advance the sweep over the epoch marks
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= dp_stat.sweep_last ? '0 : sweep_addr + AW'(1);
    end
  end

  // Result fields that come from the item
  always_ff @(posedge clk) begin
    if (cmd.exec && cur.cmd) begin
      read_hit_pre <= idx_ok && slot_seen;
    end
    if (upd) begin
      res_status <= pt_status;
      res_range  <= '0;
      res_inten  <= '0;
    end else if (cmd.read_fin) begin
      res_status <= ST_OK;
      res_range  <= read_hit ? data_rdata[63:32] : INF_BITS;
      res_inten  <= read_hit ? data_rdata[31:0] : '0;
    end
  end

  // Epoch marks: written with each point, cleared by the sweep
  assign tag_we    = store_we || cmd.sweep;
  assign tag_waddr = cmd.sweep ? sweep_addr : pt[AW-1:0];
  assign tag_wdata = cmd.sweep ? '0 : epoch_after;

  lrev_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (POINTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (read_addr),
    .rdata (tag_rdata)
  );

  // Range and intensity store
  lrev_ram #(
    .WIDTH (64),
    .DEPTH (POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (pt[AW-1:0]),
    .wdata ({cur.range_bits, cur.intensity_bits}),
    .raddr (read_addr),
    .rdata (data_rdata)
  );

  // Status to the controller
  assign dp_stat.is_read    = cur.cmd;
  assign dp_stat.need_wrap  = !cur.cmd && restart && (epoch == '1);
  assign dp_stat.sweep_last = sweep_addr == AW'(POINTS - 1);

  // Result transfer
  assign result.status             = res_status;
  assign result.frame_complete     = frame_done;
  assign result.packets_held       = (32'(packet_tally) > 32'd255) ? 8'hFF : 8'(packet_tally);
  assign result.discarded_total    = discard_tally;
  assign result.rotation_now       = frame_rotation;
  assign result.rotation_hz_now    = frame_hz;
  assign result.stamp_seconds_now  = frame_seconds;
  assign result.stamp_fraction_now = frame_fraction;
  assign result.range_out          = res_range;
  assign result.intensity_out      = res_inten;

  // A complete frame holds every packet
  a_done_full: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> (32'(packet_tally) == PACKETS))
    else $error("frame complete with missing packets");

  // No point is stored while the epoch marks are swept
  a_no_store_in_sweep: assert property (@(posedge clk) disable iff (rst)
    !(store_we && cmd.sweep))
    else $error("point store during sweep");

  // A restart without a received packet leaves the slot map empty
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    upd && restart && !mark |=> slot_received == '0)
    else $error("slot map not cleared on restart");

  // The tally matches the slot map after every update
  a_tally_map: assert property (@(posedge clk) disable iff (rst)
    $past(upd) |-> (32'(packet_tally) == $countones(slot_received)))
    else $error("packet tally disagrees with slot map");

endmodule

// File: hdl/lidar_revolution_assembler.sv
// ----------------------------------------------------------------------------
// lidar_revolution_assembler: builds one lidar revolution from packet points
// Judges packet headers by rotation number, stores points and serves reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; the item transfers at a clock edge
//   with start high and busy low. item.cmd selects a packet point (0) or a
//   read of a stored point (1).
//   Output: every item yields one result, shown on result for one cycle with
//   done high. The receiver cannot stall the block; the result must be taken
//   in that cycle. Frame fields on result show the frame after the item.
//   Timing: a packet point goes through the execute state before done; a read
//   also passes the read state (registered read of the point and epoch RAMs).
//   busy falls in the cycle done rises, so a new item can follow at once.
//   Each stored point carries an 8-bit frame epoch; when a new frame would
//   wrap the epoch, a sweep over all POINTS_PER_FRAME marks clears them
//   first (once every 255 frames).
//   Reset: synchronous, active high. After reset the block sweeps all
//   POINTS_PER_FRAME epoch marks with busy high before the first item.
// ----------------------------------------------------------------------------
module lidar_revolution_assembler #(
  parameter int unsigned CHANNELS          = lrev_pkg::CHANNELS_DEF,
  parameter int unsigned PACKETS_PER_FRAME = lrev_pkg::PACKETS_DEF,
  parameter int unsigned POINTS_PER_FRAME  = lrev_pkg::POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lrev_pkg::in_t  item,
  output logic           busy,
  output logic           done,
  output lrev_pkg::out_t result
);
  import lrev_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_stat;

  // Sequencing
  lrev_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .cmd     (ctrl_cmd),
    .busy    (busy),
    .done    (done)
  );

  // Frame state and stores
  lrev_datapath #(
    .CHANNELS (CHANNELS),
    .PACKETS  (PACKETS_PER_FRAME),
    .POINTS   (POINTS_PER_FRAME)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cmd     (ctrl_cmd),
    .dp_stat (dp_stat),
    .result  (result)
  );

endmodule
